// ----- hw/rtl/pjq_pkg.sv -----
// Shared types and codes for the priority job queue.
`default_nettype none

package pjq_pkg;

    // Default sizes of the queue.
    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int PAYLOAD_BITS_DEF = 32;

    // Action codes carried on the request channel.
    localparam logic [1:0] ACT_ENQUEUE = 2'd0;
    localparam logic [1:0] ACT_DEQUEUE = 2'd1;
    localparam logic [1:0] ACT_PEEK    = 2'd2;

    // Status codes carried on the response channel.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BADPRI = 2'd3;

    // One request beat.
    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  job_priority;
        logic [31:0] job_payload;
    } req_beat_t;

    // One response beat.
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  result_priority;
        logic [31:0] result_payload;
        logic [4:0]  entry_count;
        logic        is_full;
        logic        is_empty;
    } rsp_beat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/priority_job_queue_core.sv -----
// Priority job queue: slot RAM, scan and shift sequencer, response register.
// Enqueue, rejected requests and unused actions go straight from accept to the done state.
// Dequeue and peek scan one slot per cycle through the RAM read port; dequeue then
// shifts every entry behind the winner one slot down.
// One request is in work at a time; the next can be accepted in the cycle after a response
// loads, even while that response waits.
// Reset empties the queue at once through the fill count; the RAM is not cleared.
`default_nettype none

module priority_job_queue_core #(
    parameter int QUEUE_DEPTH  = pjq_pkg::QUEUE_DEPTH_DEF,
    parameter int PAYLOAD_BITS = pjq_pkg::PAYLOAD_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire pjq_pkg::req_beat_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output pjq_pkg::rsp_beat_t     rsp
);

    import pjq_pkg::*;

    localparam int STORE_BITS = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
    localparam int WORD_W     = 8 + STORE_BITS;
    localparam int IDX_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]      best_idx_reg, best_idx_next;
    logic                  is_deq_reg, is_deq_next;
    logic [1:0]            res_status_reg, res_status_next;
    logic [7:0]            res_pri_reg, res_pri_next;
    logic [STORE_BITS-1:0] res_pay_reg, res_pay_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_beat_t             rsp_reg, rsp_next;

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [WORD_W-1:0]     wr_data;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [WORD_W-1:0]     rd_data;

    logic [7:0]            rd_pri;
    logic [STORE_BITS-1:0] rd_pay;
    logic                  take;
    logic [IDX_W-1:0]      cur_idx;
    logic [7:0]            cur_pri;
    logic [STORE_BITS-1:0] cur_pay;
    logic                  accept;
    logic                  load_rsp;

    pjq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_pri    = rd_data[WORD_W-1 -: 8];
    assign rd_pay    = rd_data[STORE_BITS-1:0];
    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign load_rsp  = (state_reg == S_DONE) && (!rsp_valid_reg || !rsp_stall);

    // Running minimum: the first slot always wins, later slots only on a strictly smaller number.
    assign take    = (idx_reg == '0) || (rd_pri < res_pri_reg);
    assign cur_idx = take ? idx_reg : best_idx_reg;
    assign cur_pri = take ? rd_pri : res_pri_reg;
    assign cur_pay = take ? rd_pay : res_pay_reg;

    // Sequencer: enqueue write, minimum scan, shift down, then response handoff.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        best_idx_next   = best_idx_reg;
        is_deq_next     = is_deq_reg;
        res_status_next = res_status_reg;
        res_pri_next    = res_pri_reg;
        res_pay_next    = res_pay_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = rd_data;
        rd_en           = 1'b0;
        rd_addr         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    is_deq_next     = (req.action == ACT_DEQUEUE);
                    res_status_next = ST_OK;
                    res_pri_next    = '0;
                    res_pay_next    = '0;
                    idx_next        = '0;
                    state_next      = S_DONE;
                    case (req.action)
                        ACT_ENQUEUE:
                        begin
                            if (count_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else if (req.job_priority == 8'd0)
                            begin
                                res_status_next = ST_BADPRI;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = IDX_W'(count_reg);
                                wr_data    = {req.job_priority,
                                              req.job_payload[STORE_BITS-1:0]};
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        ACT_DEQUEUE, ACT_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_OK;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                best_idx_next = cur_idx;
                res_pri_next  = cur_pri;
                res_pay_next  = cur_pay;
                if ((CNT_W'(idx_reg) + CNT_W'(1)) != count_reg)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + IDX_W'(1);
                    idx_next = idx_reg + IDX_W'(1);
                end
                else if (is_deq_reg && ((CNT_W'(cur_idx) + CNT_W'(1)) != count_reg))
                begin
                    // Winner is not the last entry: start moving later entries down.
                    rd_en      = 1'b1;
                    rd_addr    = cur_idx + IDX_W'(1);
                    idx_next   = cur_idx;
                    state_next = S_SHIFT;
                end
                else
                begin
                    if (is_deq_reg)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    state_next = S_DONE;
                end
            end

            S_SHIFT:
            begin
                // Entry idx+1 has arrived; write it one slot lower.
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = rd_data;
                if ((CNT_W'(idx_reg) + CNT_W'(2)) == count_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + IDX_W'(1) + IDX_W'(1);
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_DONE:
            begin
                if (load_rsp)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Response register: loads a finished result when free or being drained.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (load_rsp)
        begin
            rsp_valid_next           = 1'b1;
            rsp_next.status          = res_status_reg;
            rsp_next.result_priority = res_pri_reg;
            rsp_next.result_payload  = 32'(res_pay_reg);
            rsp_next.entry_count     = 5'(count_reg);
            rsp_next.is_full         = (count_reg == CNT_W'(QUEUE_DEPTH));
            rsp_next.is_empty        = (count_reg == '0);
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        best_idx_reg   <= best_idx_next;
        is_deq_reg     <= is_deq_next;
        res_status_reg <= res_status_next;
        res_pri_reg    <= res_pri_next;
        res_pay_reg    <= res_pay_next;
        rsp_reg        <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/pjq_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module pjq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the priority job queue core.
`timescale 1ns / 100ps

module tb;

    import pjq_pkg::*;

    localparam int DEPTH          = QUEUE_DEPTH_DEF;
    localparam int PHASES         = 25;
    localparam int PHASE_ITEMS    = 50;
    localparam int SETTLE_CYCLES  = 2 * DEPTH + 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_PRINTED    = 100;

    // Action code that the queue leaves unused.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // One row of the directed stimulus table.
    typedef struct {
        req_beat_t beat;
        int        reps;
        bit        typed;
        rsp_beat_t want;
    } stim_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_beat_t req = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_beat_t rsp;

    // Shadow copy of the queue contents.
    logic [7:0]  shadow_pri [DEPTH];
    logic [31:0] shadow_pay [DEPTH];
    int          shadow_held = 0;
    int          peak_held = 0;

    rsp_beat_t   expected_rsp [$];
    stim_row_t   dir_rows [$];

    bit          quiet = 1'b0;
    int          mismatches = 0;
    int          rsp_seen = 0;
    int          idle_cycles = 0;
    int          requests_sent = 0;
    int          action_seen [4] = '{0, 0, 0, 0};
    int          status_seen [4] = '{0, 0, 0, 0};

    priority_job_queue_core #(
        .QUEUE_DEPTH  (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS_DEF)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Response beat for a given outcome; the flags follow from the count.
    function automatic rsp_beat_t make_rsp(logic [1:0] status, logic [7:0] pri,
                                           logic [31:0] pay, int count);
        rsp_beat_t r;
        r.status          = status;
        r.result_priority = pri;
        r.result_payload  = pay;
        r.entry_count     = count[4:0];
        r.is_full         = (count == DEPTH);
        r.is_empty        = (count == 0);
        return r;
    endfunction

    // Applies one request to the shadow queue and returns the response it causes.
    function automatic rsp_beat_t queue_predict(req_beat_t b);
        rsp_beat_t r;
        int        best;
        r = make_rsp(ST_OK, '0, '0, 0);
        case (b.action)
            ACT_ENQUEUE:
            begin
                // A full queue is reported even when the priority is also invalid.
                if (shadow_held >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else if (b.job_priority == '0)
                begin
                    r.status = ST_BADPRI;
                end
                else
                begin
                    shadow_pri[shadow_held] = b.job_priority;
                    shadow_pay[shadow_held] = b.job_payload;
                    shadow_held++;
                end
            end
            ACT_DEQUEUE, ACT_PEEK:
            begin
                if (shadow_held == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    // Lowest number wins; the earliest job wins a tie.
                    best = 0;
                    for (int i = 1; i < shadow_held; i++)
                    begin
                        if (shadow_pri[i] < shadow_pri[best])
                        begin
                            best = i;
                        end
                    end
                    r.result_priority = shadow_pri[best];
                    r.result_payload  = shadow_pay[best];
                    if (b.action == ACT_DEQUEUE)
                    begin
                        for (int i = best; i + 1 < shadow_held; i++)
                        begin
                            shadow_pri[i] = shadow_pri[i + 1];
                            shadow_pay[i] = shadow_pay[i + 1];
                        end
                        shadow_held--;
                        shadow_pri[shadow_held] = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (shadow_held > peak_held)
        begin
            peak_held = shadow_held;
        end
        r.entry_count = shadow_held[4:0];
        r.is_full     = (shadow_held == DEPTH);
        r.is_empty    = (shadow_held == 0);
        return r;
    endfunction

    // Random request; fill_bias is the chance in percent of an enqueue.
    function automatic req_beat_t random_request(int unsigned fill_bias);
        req_beat_t   b;
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < fill_bias)
        begin
            b.action = ACT_ENQUEUE;
        end
        else if (roll < 97)
        begin
            b.action = ($urandom_range(3) == 0) ? ACT_PEEK : ACT_DEQUEUE;
        end
        else
        begin
            b.action = ACT_UNUSED;
        end
        // Small priorities make ties common; a few are invalid or the extreme.
        roll = $urandom_range(99);
        if (roll < 3)
        begin
            b.job_priority = '0;
        end
        else if (roll < 50)
        begin
            b.job_priority = 8'($urandom_range(1, 4));
        end
        else if (roll < 90)
        begin
            b.job_priority = 8'($urandom_range(1, 255));
        end
        else
        begin
            b.job_priority = '1;
        end
        roll = $urandom_range(99);
        if (roll < 5)
        begin
            b.job_payload = '0;
        end
        else if (roll < 10)
        begin
            b.job_payload = '1;
        end
        else
        begin
            b.job_payload = $urandom;
        end
        return b;
    endfunction

    task automatic add_row(logic [1:0] action, logic [7:0] pri, logic [31:0] pay,
                           int reps, bit typed, rsp_beat_t want);
        stim_row_t row;
        row.beat.action       = action;
        row.beat.job_priority = pri;
        row.beat.job_payload  = pay;
        row.reps              = reps;
        row.typed             = typed;
        row.want              = want;
        dir_rows.push_back(row);
    endtask

    // Sends one request beat and records its expected response once accepted.
    task automatic send_request(req_beat_t b, bit typed, rsp_beat_t typed_rsp);
        int unsigned gap;
        rsp_beat_t   predicted;
        gap = quiet ? 0 : $urandom_range(15);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= b;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        predicted = queue_predict(b);
        expected_rsp.push_back(typed ? typed_rsp : predicted);
        requests_sent++;
        action_seen[b.action]++;
        status_seen[predicted.status]++;
        @(negedge clk);
    endtask

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
        begin
            $display("%0t: response %0d mismatch: %s", $time, rsp_seen, what);
        end
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    // Response sink: stalls a random number of cycles before taking each beat.
    initial
    begin : rsp_sink
        int unsigned hold;
        @(negedge clk);
        forever
        begin
            hold = quiet ? 0 : $urandom_range(15);
            if (hold != 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(negedge clk);
                rsp_stall <= 1'b0;
            end
            @(posedge clk);
            while (!(rsp_valid && !rsp_stall)) @(posedge clk);
            @(negedge clk);
        end
    end

    // Response checker and watchdog.
    always @(posedge clk)
    begin : rsp_check
        rsp_beat_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected beat %p", rsp));
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    compare_field("status", 32'(rsp.status), 32'(want.status));
                    compare_field("result_priority", 32'(rsp.result_priority),
                                  32'(want.result_priority));
                    compare_field("result_payload", rsp.result_payload,
                                  want.result_payload);
                    compare_field("entry_count", 32'(rsp.entry_count),
                                  32'(want.entry_count));
                    compare_field("is_full", 32'(rsp.is_full), 32'(want.is_full));
                    compare_field("is_empty", 32'(rsp.is_empty), 32'(want.is_empty));
                end
                rsp_seen++;
            end
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no beat moved for %0d cycles.", idle_cycles);
                $display("tb failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        stim_row_t   row;
        req_beat_t   b;
        int unsigned fill_bias;

        // Directed table: empty queue, invalid priority, ties, full queue, unused action.
        add_row(ACT_DEQUEUE, 8'h00, 32'h0000_0000, 1, 1'b1,
                make_rsp(ST_EMPTY, 8'h00, 32'h0, 0));
        add_row(ACT_PEEK, 8'h00, 32'h0000_0000, 1, 1'b1,
                make_rsp(ST_EMPTY, 8'h00, 32'h0, 0));
        add_row(ACT_ENQUEUE, 8'h00, 32'hDEAD_BEEF, 1, 1'b1,
                make_rsp(ST_BADPRI, 8'h00, 32'h0, 0));
        add_row(ACT_ENQUEUE, 8'hFF, 32'hFFFF_FFFF, 1, 1'b1,
                make_rsp(ST_OK, 8'h00, 32'h0, 1));
        add_row(ACT_ENQUEUE, 8'h01, 32'h0000_0000, 1, 1'b1,
                make_rsp(ST_OK, 8'h00, 32'h0, 2));
        add_row(ACT_ENQUEUE, 8'h01, 32'hA5A5_A5A5, 1, 1'b1,
                make_rsp(ST_OK, 8'h00, 32'h0, 3));
        add_row(ACT_PEEK, 8'h00, 32'h0000_0000, 1, 1'b1,
                make_rsp(ST_OK, 8'h01, 32'h0, 3));
        add_row(ACT_ENQUEUE, 8'h02, 32'h0000_1000, DEPTH - 3, 1'b0, '0);
        add_row(ACT_ENQUEUE, 8'h01, 32'h1234_5678, 1, 1'b1,
                make_rsp(ST_FULL, 8'h00, 32'h0, DEPTH));
        add_row(ACT_ENQUEUE, 8'h00, 32'h1234_5678, 1, 1'b1,
                make_rsp(ST_FULL, 8'h00, 32'h0, DEPTH));
        add_row(ACT_UNUSED, 8'h55, 32'h5555_5555, 1, 1'b1,
                make_rsp(ST_OK, 8'h00, 32'h0, DEPTH));
        add_row(ACT_DEQUEUE, 8'h00, 32'h0000_0000, 1, 1'b1,
                make_rsp(ST_OK, 8'h01, 32'h0, DEPTH - 1));
        add_row(ACT_DEQUEUE, 8'h00, 32'h0000_0000, 1, 1'b1,
                make_rsp(ST_OK, 8'h01, 32'hA5A5_A5A5, DEPTH - 2));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[r])
        begin
            row = dir_rows[r];
            for (int k = 0; k < row.reps; k++)
            begin
                b = row.beat;
                b.job_priority = b.job_priority + 8'(k);
                b.job_payload  = b.job_payload + 32'(k);
                send_request(b, row.typed, row.want);
            end
        end

        // Random phases alternate between filling, draining and a balanced mix.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            quiet     = (phase % 4 == 3);
            fill_bias = (phase % 3 == 0) ? 75 : ((phase % 3 == 1) ? 25 : 50);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_request(random_request(fill_bias), 1'b0, '0);
            end
            // Now and then let the queue answer everything before going on.
            if (phase % 5 == 4)
            begin
                req_valid <= 1'b0;
                @(negedge clk);
                while (expected_rsp.size() != 0) @(negedge clk);
            end
        end
        quiet = 1'b0;

        req_valid <= 1'b0;
        while (expected_rsp.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Ran %0d requests: %0d enqueue, %0d dequeue, %0d peek, %0d unused; peak fill %0d of %0d.",
                 requests_sent, action_seen[ACT_ENQUEUE], action_seen[ACT_DEQUEUE],
                 action_seen[ACT_PEEK], action_seen[ACT_UNUSED], peak_held, DEPTH);
        $display("Outcomes: %0d ok, %0d dropped as full, %0d on empty, %0d bad priority.",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
                 status_seen[ST_BADPRI]);
        if (mismatches == 0)
        begin
            $display("tb passed");
        end
        else
        begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
